// ===== rtl/kss_pkg.sv =====
// kss_pkg: sizes, slot encoding and controller/datapath interface types
// for the shared-store stack core. No dependencies.
package kss_pkg;

   localparam int CAPACITY = 128;
   localparam int STACKS   = 64;

   localparam int VALUE_W  = 32;
   localparam int SID_W    = 6;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int SLOT_W   = $clog2(CAPACITY + 1);
   localparam int STACK_AW = (STACKS > 1) ? $clog2(STACKS) : 1;

   localparam logic [SLOT_W-1:0] NIL_SLOT = SLOT_W'(CAPACITY);

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic capture;      // transfer accepted: latch request, first reads
      logic push_commit;  // push: write back or flag full, emit result
      logic pop_read;     // pop: read link and data at top slot
      logic pop_commit;   // pop: write back, emit result
      logic empty_done;   // pop on empty stack: emit flag
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic top_nil;
   } status_type;

endpackage

// ===== rtl/k_stacks_shared_store_core.sv =====
// k_stacks_shared_store_core: 64 stacks in one 128-slot store, linked free list.
// Depends on kss_pkg, kss_ctrl, kss_datapath.
// Push: accept, commit, then a registered result strobe; taken only when idle.
// Pop: top read, then link/data read at that slot, then commit; empty pop ends
// after the top read. The steps follow the dependent top and link store reads.
// Synchronous reset: all stacks empty, free list 0..127 in order, ready at once.
module k_stacks_shared_store_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_kind,
   input  logic [kss_pkg::SID_W-1:0]          req_stack_id,
   input  logic signed [kss_pkg::VALUE_W-1:0] req_push_value,
   output logic                               rsp_valid,
   output logic signed [kss_pkg::VALUE_W-1:0] rsp_pop_value,
   output logic                               rsp_was_empty,
   output logic                               rsp_was_full
);
   import kss_pkg::*;

   cmd_type    cmd;
   status_type status;

   kss_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   kss_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_stack_id   (req_stack_id),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_was_empty  (rsp_was_empty),
      .rsp_was_full   (rsp_was_full)
   );

endmodule

// ===== rtl/kss_ctrl.sv =====
// kss_ctrl: operation sequencer for the shared-store stack core.
// Depends on kss_pkg.
module kss_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_kind,
   input  kss_pkg::status_type status,
   output kss_pkg::cmd_type   cmd,
   output logic               busy
);
   import kss_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PUSH = 2'd1;
   localparam logic [1:0] ST_POP1 = 2'd2;
   localparam logic [1:0] ST_POP2 = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = (req_kind == KIND_POP) ? ST_POP1 : ST_PUSH;
            end
         end
         ST_PUSH: begin
            cmd.push_commit = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_POP1: begin
            if (status.top_nil) begin
               cmd.empty_done = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.pop_read = 1'b1;
               state_in     = ST_POP2;
            end
         end
         ST_POP2: begin
            cmd.pop_commit = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/kss_datapath.sv =====
// kss_datapath: top, link and data stores, free-list head and result registers.
// Depends on kss_pkg.
module kss_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  kss_pkg::cmd_type                  cmd,
   output kss_pkg::status_type               status,
   input  logic [kss_pkg::SID_W-1:0]         req_stack_id,
   input  logic signed [kss_pkg::VALUE_W-1:0] req_push_value,
   output logic                              rsp_valid,
   output logic signed [kss_pkg::VALUE_W-1:0] rsp_pop_value,
   output logic                              rsp_was_empty,
   output logic                              rsp_was_full
);
   import kss_pkg::*;

   logic [SLOT_W-1:0]  tops_mem [STACKS];
   logic [SLOT_W-1:0]  link_mem [CAPACITY];
   logic [VALUE_W-1:0] data_mem [CAPACITY];

   // unwritten top / link entries read as their reset value
   logic [STACKS-1:0]   top_vld_ff;
   logic [CAPACITY-1:0] link_vld_ff;

   logic [SLOT_W-1:0]   free_head_ff;
   logic [STACK_AW-1:0] sid_ff;
   logic [VALUE_W-1:0]  val_ff;

   logic [SLOT_W-1:0]  top_rd_ff;
   logic               top_rd_vld_ff;
   logic [SLOT_W-1:0]  link_rd_ff;
   logic               link_rd_vld_ff;
   logic [IDX_W-1:0]   link_addr_ff;
   logic [VALUE_W-1:0] data_rd_ff;

   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_empty_ff;
   logic               rsp_full_ff;

   logic [SLOT_W-1:0]   top_eff;
   logic [SLOT_W-1:0]   link_eff;
   logic [IDX_W-1:0]    link_addr_in;
   logic [STACK_AW-1:0] req_sid;
   logic                head_nil;
   logic                do_push;
   logic [IDX_W-1:0]    head_idx;
   logic [IDX_W-1:0]    top_idx;

   assign req_sid  = req_stack_id[STACK_AW-1:0];
   assign top_eff  = top_rd_vld_ff ? top_rd_ff : NIL_SLOT;
   assign link_eff = link_rd_vld_ff ? link_rd_ff
                                    : SLOT_W'({1'b0, link_addr_ff} + 1'b1);
   assign head_nil = (free_head_ff == NIL_SLOT);
   assign do_push  = cmd.push_commit && !head_nil;
   assign head_idx = free_head_ff[IDX_W-1:0];
   assign top_idx  = top_eff[IDX_W-1:0];

   assign link_addr_in = cmd.capture ? head_idx : top_idx;
   assign status.top_nil = (top_eff == NIL_SLOT);

   // request capture and first reads
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sid_ff        <= req_sid;
         val_ff        <= req_push_value;
         top_rd_ff     <= tops_mem[req_sid];
      end
   end

   // link store: one read, one write port
   always_ff @(posedge clock) begin
      if (cmd.capture || cmd.pop_read) begin
         link_rd_ff   <= link_mem[link_addr_in];
         link_addr_ff <= link_addr_in;
      end
      if (do_push) begin
         link_mem[head_idx] <= top_eff;
      end else if (cmd.pop_commit) begin
         link_mem[top_idx] <= free_head_ff;
      end
   end

   // data store
   always_ff @(posedge clock) begin
      if (cmd.pop_read) begin
         data_rd_ff <= data_mem[top_idx];
      end
      if (do_push) begin
         data_mem[head_idx] <= val_ff;
      end
   end

   // top store
   always_ff @(posedge clock) begin
      if (do_push) begin
         tops_mem[sid_ff] <= free_head_ff;
      end else if (cmd.pop_commit) begin
         tops_mem[sid_ff] <= link_eff;
      end
   end

   // control state: valid bits, free-list head, result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         top_vld_ff     <= '0;
         link_vld_ff    <= '0;
         free_head_ff   <= '0;
         top_rd_vld_ff  <= 1'b0;
         link_rd_vld_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.capture) begin
            top_rd_vld_ff <= top_vld_ff[req_sid];
         end
         if (cmd.capture || cmd.pop_read) begin
            link_rd_vld_ff <= link_vld_ff[link_addr_in];
         end
         if (do_push) begin
            link_vld_ff[head_idx] <= 1'b1;
            top_vld_ff[sid_ff]    <= 1'b1;
            free_head_ff          <= link_eff;
         end else if (cmd.pop_commit) begin
            link_vld_ff[top_idx] <= 1'b1;
            free_head_ff         <= top_eff;
         end
         rsp_valid_ff <= cmd.push_commit || cmd.pop_commit || cmd.empty_done;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.push_commit || cmd.pop_commit || cmd.empty_done) begin
         rsp_value_ff <= cmd.pop_commit ? data_rd_ff : '0;
         rsp_empty_ff <= cmd.empty_done;
         rsp_full_ff  <= cmd.push_commit && head_nil;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pop_value = rsp_value_ff;
   assign rsp_was_empty = rsp_empty_ff;
   assign rsp_was_full  = rsp_full_ff;

endmodule

// ===== rtl/kss_checker.sv =====
// kss_checker: port-level checks on the stack core, bound to the top level.
// Depends on kss_pkg and k_stacks_shared_store_core.
module kss_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic signed [kss_pkg::VALUE_W-1:0] rsp_pop_value,
   input logic                               rsp_was_empty,
   input logic                               rsp_was_full
);
   import kss_pkg::*;

   // an accepted transfer makes the core busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("core not busy after accept");

   // a result appears only once the operation has finished
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_was_empty && rsp_was_full))
      else $error("empty and full flagged together");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_was_empty || rsp_was_full)) |-> (rsp_pop_value == '0))
      else $error("flagged result carries a value");

   // no result unless the core was busy in the previous cycle
   a_rsp_needs_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without operation");

endmodule

bind k_stacks_shared_store_core kss_checker u_kss_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_pop_value (rsp_pop_value),
   .rsp_was_empty (rsp_was_empty),
   .rsp_was_full  (rsp_was_full)
);
